[rtl/core/positional_list_engine_assert.svh]
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising clock edge outside reset.
`define PLE_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("positional_list_engine: assertion failed");

// Checked on every rising clock edge, reset included.
`define PLE_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("positional_list_engine: assertion failed");

`else

`define PLE_ASSERT(name, clk, rst, prop)
`define PLE_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

[rtl/core/plist_pkg.sv]
package plist_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_DUMP   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_out;
      logic               last;
   } rsp_type;

endpackage

[rtl/core/positional_list_engine.sv]
// Ordered list of up to CAPACITY signed words held in one single-port-read,
// single-port-write memory with a registered read. One request is worked at a
// time; req_stall stays high until its last response beat is in the output
// register. Insert at position p does one memory read per moved entry, then
// a drain state, the new word's write and the response; an append goes
// straight to the write. Delete reads the entries from p on, moves all but the
// deleted word down, then responds. Dump reads each entry before loading it
// as a beat, one entry at a time. Errors and an empty dump go straight to
// the response. Kind 3 is dropped with no response. The memory needs no
// clearing after reset: only entries below the count are ever read.
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plist_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plist_pkg::rsp_type rsp_data
);
   import plist_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SHIFT   = 7'b0000010,
      S_DRAIN   = 7'b0000100,
      S_PUT     = 7'b0001000,
      S_RESP    = 7'b0010000,
      S_DUMP_RD = 7'b0100000,
      S_DUMP_LD = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   src_ff, src_in;
   logic [AW-1:0]   stop_ff, stop_in;
   logic [AW-1:0]   prev_ff, prev_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic            pv_ff, pv_in;
   logic            up_ff, up_in;
   rsp_type         res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic [31:0]     mem [CAPACITY];
   logic [31:0]     mem_rd_ff;
   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_wa, mem_ra;
   logic [31:0]     mem_wd;

   logic            slot_free, rsp_load;
   logic            ins_ok, del_ok, dump_last;
   logic [AW-1:0]   pos_m1;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign pos_m1    = AW'(req_data.position - 7'd1);
   assign ins_ok    = (req_data.position != 7'd0) &&
                      ({1'b0, req_data.position} <= (8'(count_ff) + 8'd1));
   assign del_ok    = (req_data.position != 7'd0) &&
                      (req_data.position <= 7'(count_ff));
   assign dump_last = (CW'(idx_ff) == (count_ff - 1'b1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      src_in      = src_ff;
      stop_in     = stop_ff;
      prev_in     = prev_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      pv_in       = pv_ff;
      up_in       = up_ff;
      res_in      = res_ff;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      mem_we      = 1'b0;
      mem_wa      = prev_ff;
      mem_wd      = mem_rd_ff;
      mem_re      = 1'b0;
      mem_ra      = src_ff;

      // retire the word read last cycle: move it one slot, or keep it as
      // the deleted word when it came from the delete position
      if ((state_ff == S_SHIFT || state_ff == S_DRAIN) && pv_ff) begin
         if (up_ff) begin
            mem_we = 1'b1;
            mem_wa = AW'(prev_ff + 1'b1);
         end else if (prev_ff == pos_ff) begin
            res_in.value_out = mem_rd_ff;
         end else begin
            mem_we = 1'b1;
            mem_wa = AW'(prev_ff - 1'b1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  KIND_INSERT: begin
                     state_in = S_RESP;
                     if (!ins_ok) begin
                        res_in = '{status: ST_BADPOS, value_out: '0, last: 1'b1};
                     end else if (count_ff == CW'(CAPACITY)) begin
                        res_in = '{status: ST_FULL, value_out: '0, last: 1'b1};
                     end else begin
                        res_in   = '{status: ST_OK, value_out: req_data.value,
                                     last: 1'b1};
                        count_in = count_ff + 1'b1;
                        pos_in   = pos_m1;
                        up_in    = 1'b1;
                        pv_in    = 1'b0;
                        if (CW'(pos_m1) == count_ff) begin
                           state_in = S_PUT;
                        end else begin
                           src_in   = AW'(count_ff - 1'b1);
                           stop_in  = pos_m1;
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  KIND_DELETE: begin
                     if (!del_ok) begin
                        res_in   = '{status: ST_BADPOS, value_out: '0, last: 1'b1};
                        state_in = S_RESP;
                     end else begin
                        res_in   = '{status: ST_OK, value_out: '0, last: 1'b1};
                        count_in = count_ff - 1'b1;
                        pos_in   = pos_m1;
                        up_in    = 1'b0;
                        pv_in    = 1'b0;
                        src_in   = pos_m1;
                        stop_in  = AW'(count_ff - 1'b1);
                        state_in = S_SHIFT;
                     end
                  end
                  KIND_DUMP: begin
                     if (count_ff == '0) begin
                        res_in   = '{status: ST_EMPTY, value_out: '0, last: 1'b1};
                        state_in = S_RESP;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SHIFT: begin
            mem_re  = 1'b1;
            mem_ra  = src_ff;
            prev_in = src_ff;
            pv_in   = 1'b1;
            if (src_ff == stop_ff) begin
               state_in = S_DRAIN;
            end else begin
               src_in = up_ff ? AW'(src_ff - 1'b1) : AW'(src_ff + 1'b1);
            end
         end
         S_DRAIN: begin
            pv_in    = 1'b0;
            state_in = up_ff ? S_PUT : S_RESP;
         end
         S_PUT: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff;
            mem_wd   = res_ff.value_out;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = res_ff;
               state_in    = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            mem_re   = 1'b1;
            mem_ra   = idx_ff;
            state_in = S_DUMP_LD;
         end
         S_DUMP_LD: begin
            // mem_rd_ff holds while we wait for the output register
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{status: ST_OK, value_out: mem_rd_ff, last: dump_last};
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = AW'(idx_ff + 1'b1);
                  state_in = S_DUMP_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      stop_ff     <= stop_in;
      prev_ff     <= prev_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      up_ff       <= up_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PLE_ASSERT(a_count_bound, clock, reset, (count_ff <= CW'(CAPACITY)))
   `PLE_ASSERT(a_load_free, clock, reset, (rsp_load |-> slot_free))
   `PLE_ASSERT(a_no_rw_clash, clock, reset, ((mem_we && mem_re) |-> (mem_wa != mem_ra)))
   `PLE_ASSERT(a_del_count, clock, reset,
      ((req_valid && !req_stall && (req_data.kind == KIND_DELETE) && del_ok)
         |=> (count_ff == ($past(count_ff) - 1'b1))))

endmodule

[tb/sv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import plist_pkg::*;

   localparam int          LIST_CAPACITY = 64;
   localparam logic [1:0]  KIND_IGNORED  = 2'd3;
   localparam int          TAIL_CYCLES   = 20;
   localparam int          CYCLE_LIMIT   = 2_000_000;
   localparam int          PRINT_LIMIT   = 60;

   typedef enum {MIX_OPS, FILL_OPS, DRAIN_OPS} stim_mode_type;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type beat;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the list
   logic [31:0] list_words [LIST_CAPACITY];
   int unsigned list_count = 0;

   rsp_type          owed_beats [$];
   directed_row_type directed_rows [$];

   int unsigned mismatches = 0;
   int unsigned beats_seen = 0;
   int unsigned cycle_count = 0;
   int unsigned send_calm = 0;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;
   logic        winding_down = 1'b0;

   positional_list_engine #(.CAPACITY(LIST_CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("positional_list_engine: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] beat %0d: %s", $time, beats_seen, what);
   endtask

   function automatic void owe_beat(input logic [1:0] st, input logic [31:0] word,
                                    input logic lst);
      rsp_type beat;
      beat = {st, word, lst};
      owed_beats.push_back(beat);
   endfunction

   // updates the shadow list and queues the beats one request should produce
   function automatic void run_list_op(input req_type r);
      int unsigned p;
      int unsigned k;
      logic [31:0] taken;
      p = r.position;
      case (r.kind)
         KIND_INSERT: begin
            if (p < 1 || p > list_count + 1) begin
               owe_beat(ST_BADPOS, '0, 1'b1);
            end else if (list_count >= LIST_CAPACITY) begin
               owe_beat(ST_FULL, '0, 1'b1);
            end else begin
               for (k = list_count; k > p - 1; k--)
                  list_words[k] = list_words[k - 1];
               list_words[p - 1] = r.value;
               list_count++;
               owe_beat(ST_OK, r.value, 1'b1);
            end
         end
         KIND_DELETE: begin
            if (p < 1 || p > list_count) begin
               owe_beat(ST_BADPOS, '0, 1'b1);
            end else begin
               taken = list_words[p - 1];
               for (k = p - 1; k + 1 < list_count; k++)
                  list_words[k] = list_words[k + 1];
               list_count--;
               owe_beat(ST_OK, taken, 1'b1);
            end
         end
         KIND_DUMP: begin
            if (list_count == 0) begin
               owe_beat(ST_EMPTY, '0, 1'b1);
            end else begin
               for (k = 0; k < list_count; k++)
                  owe_beat(ST_OK, list_words[k], (k + 1 == list_count));
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int unsigned pick_idle();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request(input stim_mode_type mode);
      req_type     r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      r.value = pick_value();
      r.position = 7'($urandom_range(0, 127));
      r.kind = 2'($urandom_range(0, 3));
      case (mode)
         FILL_OPS: begin
            r.kind = KIND_INSERT;
            // at capacity a legal position hits the full check
            if (roll < 90) r.position = 7'($urandom_range(1, list_count + 1));
         end
         DRAIN_OPS: begin
            if (roll < 85) begin
               r.kind = KIND_DELETE;
               if (list_count != 0) r.position = 7'($urandom_range(1, list_count));
            end else if (roll < 92) begin
               r.kind = KIND_DELETE;
            end
         end
         default: begin
            if (roll < 45) begin
               r.kind = KIND_INSERT;
               if ($urandom_range(0, 9) != 0)
                  r.position = 7'($urandom_range(1, list_count + 1));
            end else if (roll < 75) begin
               r.kind = KIND_DELETE;
               if (list_count != 0 && $urandom_range(0, 9) != 0)
                  r.position = 7'($urandom_range(1, list_count));
            end else if (roll < 85) begin
               r.kind = KIND_DUMP;
            end
         end
      endcase
      return r;
   endfunction

   task automatic table_row(input logic typed, input logic [1:0] kind, input logic [6:0] pos,
                            input logic [31:0] word, input logic [1:0] st,
                            input logic [31:0] word_out);
      directed_row_type row;
      row.req = {kind, pos, word};
      row.typed = typed;
      row.beat = {st, word_out, 1'b1};
      directed_rows.push_back(row);
   endtask

   // called and returns at a falling edge
   task automatic send_request(input req_type r, input logic typed, input rsp_type typed_beat);
      int unsigned gap;
      int unsigned held;
      if (send_calm > 0) begin
         gap = 0;
         send_calm--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap = 0;
         send_calm = $urandom_range(5, 20);
      end else begin
         gap = pick_idle();
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      held = owed_beats.size();
      run_list_op(r);
      if (typed) begin
         while (owed_beats.size() > held) void'(owed_beats.pop_back());
         owed_beats.push_back(typed_beat);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (winding_down) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (calm_left > 0) begin
         rsp_stall <= 1'b0;
         calm_left--;
      end else if ($urandom_range(0, 31) == 0) begin
         rsp_stall <= 1'b0;
         calm_left = $urandom_range(20, 80);
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = pick_idle();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         beats_seen++;
         if (owed_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat status %0d value %0d last %0d",
                                      rsp_data.status, rsp_data.value_out, rsp_data.last));
         end else begin
            want = owed_beats.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.value_out !== want.value_out)
               report_mismatch($sformatf("value_out %0d, want %0d",
                                         rsp_data.value_out, want.value_out));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0d, want %0d", rsp_data.last, want.last));
         end
      end
   end

   initial begin : stimulus
      int unsigned n;
      table_row(1'b1, KIND_DUMP,    7'd0,   32'h0000_0000, ST_EMPTY,  32'h0000_0000);
      table_row(1'b1, KIND_DELETE,  7'd1,   32'h0000_0000, ST_BADPOS, 32'h0000_0000);
      table_row(1'b1, KIND_INSERT,  7'd0,   32'h1234_5678, ST_BADPOS, 32'h0000_0000);
      table_row(1'b1, KIND_INSERT,  7'd2,   32'h1234_5678, ST_BADPOS, 32'h0000_0000);
      table_row(1'b1, KIND_INSERT,  7'd1,   32'h7FFF_FFFF, ST_OK,     32'h7FFF_FFFF);
      table_row(1'b1, KIND_INSERT,  7'd2,   32'h8000_0000, ST_OK,     32'h8000_0000);
      table_row(1'b1, KIND_INSERT,  7'd1,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b1, KIND_INSERT,  7'd2,   32'hFFFF_FFFF, ST_OK,     32'hFFFF_FFFF);
      table_row(1'b0, KIND_IGNORED, 7'd127, 32'hFFFF_FFFF, ST_OK,     32'h0000_0000);
      table_row(1'b1, KIND_INSERT,  7'd127, 32'h0000_0005, ST_BADPOS, 32'h0000_0000);
      table_row(1'b1, KIND_DELETE,  7'd0,   32'h0000_0000, ST_BADPOS, 32'h0000_0000);
      table_row(1'b1, KIND_DELETE,  7'd127, 32'h0000_0000, ST_BADPOS, 32'h0000_0000);
      table_row(1'b0, KIND_DUMP,    7'd0,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b1, KIND_DELETE,  7'd5,   32'h0000_0000, ST_BADPOS, 32'h0000_0000);
      table_row(1'b0, KIND_DELETE,  7'd4,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b1, KIND_INSERT,  7'd4,   32'h55AA_55AA, ST_OK,     32'h55AA_55AA);
      table_row(1'b1, KIND_INSERT,  7'd3,   32'h2AAA_AAAA, ST_OK,     32'h2AAA_AAAA);
      table_row(1'b0, KIND_DELETE,  7'd1,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b0, KIND_DELETE,  7'd2,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b0, KIND_IGNORED, 7'd0,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b0, KIND_DUMP,    7'd0,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b0, KIND_DELETE,  7'd1,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b0, KIND_DELETE,  7'd1,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b0, KIND_DELETE,  7'd1,   32'h0000_0000, ST_OK,     32'h0000_0000);
      table_row(1'b1, KIND_DUMP,    7'd0,   32'h0000_0000, ST_EMPTY,  32'h0000_0000);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].beat);

      for (n = 0; n < 40; n++) send_request(random_request(MIX_OPS), 1'b0, '0);
      // fill to capacity, then push against the full store and dump it all
      while (list_count < LIST_CAPACITY) send_request(random_request(FILL_OPS), 1'b0, '0);
      for (n = 0; n < 6; n++) send_request(random_request(FILL_OPS), 1'b0, '0);
      send_request({KIND_DUMP, 7'($urandom_range(0, 127)), 32'($urandom)}, 1'b0, '0);
      while (list_count > 0) send_request(random_request(DRAIN_OPS), 1'b0, '0);
      send_request({KIND_DUMP, 7'($urandom_range(0, 127)), 32'($urandom)}, 1'b0, '0);
      for (n = 0; n < 20; n++) send_request(random_request(MIX_OPS), 1'b0, '0);
      req_valid <= 1'b0;

      while (owed_beats.size() != 0) @(posedge clock);
      winding_down = 1'b1;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("positional_list_engine: match");
      end else begin
         $display("positional_list_engine: mismatch");
      end
      $finish;
   end

endmodule
